@@ sv/cda_pkg.sv @@
// Shared types, constants and calendar helper functions for the date adder.
package cda_pkg;

  // Highest year accepted by a set request.
  localparam logic [11:0] MAX_SET_YEAR = 12'd3000;
  // Years never go past this value.
  localparam logic [11:0] YEAR_LIMIT   = 12'd4095;

  // Reset values of the date and of the default registers.
  localparam logic [4:0]  RESET_DAY    = 5'd7;
  localparam logic [3:0]  RESET_MONTH  = 4'd8;
  localparam logic [11:0] RESET_YEAR   = 12'd1986;

  localparam logic [3:0]  MONTH_JAN    = 4'd1;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_MAR    = 4'd3;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [5:0]  LEAP_DAY     = 6'd29;

  // Reciprocal of 100 scaled by 2^19; exact for every 12-bit year.
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int          RECIP_SHIFT  = 19;

  typedef enum logic [1:0] {
    ACT_SET        = 2'd0,
    ACT_ADD_DAYS   = 2'd1,
    ACT_ADD_MONTHS = 2'd2,
    ACT_ADD_YEARS  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_DEFAULT_DAY   = 2'd0,
    REG_DEFAULT_MONTH = 2'd1,
    REG_DEFAULT_YEAR  = 2'd2
  } cfg_reg_t;

  // Operations of the shared date step unit.
  typedef enum logic [1:0] {
    OP_DAY   = 2'd0,
    OP_MONTH = 2'd1,
    OP_YEARS = 2'd2,
    OP_FEB   = 2'd3
  } step_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_DAYS,
    S_MONTHS,
    S_YEARS,
    S_FEB,
    S_DONE
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [5:0]  new_day;
    logic [3:0]  new_month;
    logic [11:0] new_year;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [11:0] year_out;
    logic [2:0]  fallback_flags;
    logic        year_saturated;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } date_t;

  typedef struct packed {
    date_t date;
    logic  sat;
  } step_res_t;

  typedef struct packed {
    date_t      date;
    logic [2:0] flags;
  } set_res_t;

  // Days in a month for a common year; zero for a month code out of range.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Gregorian leap test. The quotient by 100 comes from a reciprocal
  // multiply, so the remainders by 100 and 400 need no divider.
  function automatic logic is_leap(input logic [11:0] y);
    logic [24:0] prod;
    logic [5:0]  q;
    logic [11:0] r;
    prod = {13'd0, y} * {12'd0, RECIP_100};
    q    = prod[RECIP_SHIFT +: 6];
    r    = y - 12'({6'd0, q} * 12'd100);
    return (y[1:0] == 2'b00) && ((r[6:0] != 7'd0) || (q[1:0] == 2'b00));
  endfunction

  // A day is valid if it lies within the month, or is 29 February of a leap year.
  function automatic logic day_ok(input logic [5:0] d, input logic [3:0] m,
                                  input logic [11:0] y);
    logic [4:0] len;
    len = month_len(m);
    return ((d != 6'd0) && (d <= {1'b0, len})) ||
           ((m == MONTH_FEB) && (d == LEAP_DAY) && is_leap(y));
  endfunction

endpackage

@@ sv/cda_set_check.sv @@
// Validation of a set request against the default registers.
module cda_set_check (
  input  cda_pkg::in_item_t item,
  input  logic [4:0]        default_day,
  input  logic [3:0]        default_month,
  input  logic [11:0]       default_year,
  output cda_pkg::set_res_t res
);
  import cda_pkg::*;

  logic        month_valid;
  logic        year_valid;
  logic [3:0]  month_dflt;
  logic [3:0]  month_sel;
  logic [11:0] year_sel;
  logic        day_valid;

  // Month and year are resolved first; the day is checked against them.
  always_comb begin
    month_valid = (item.new_month >= MONTH_JAN) && (item.new_month <= MONTH_DEC);
    year_valid  = (item.new_year != 12'd0) && (item.new_year <= MAX_SET_YEAR);

    if (default_month == 4'd0) begin
      month_dflt = MONTH_JAN;
    end else if (default_month > MONTH_DEC) begin
      month_dflt = MONTH_DEC;
    end else begin
      month_dflt = default_month;
    end

    month_sel = month_valid ? item.new_month : month_dflt;
    year_sel  = year_valid ? item.new_year : default_year;
    day_valid = day_ok(item.new_day, month_sel, year_sel);

    res.date.month = month_sel;
    res.date.year  = year_sel;
    if (day_valid) begin
      res.date.day = item.new_day;
    end else if (default_day == 5'd0) begin
      res.date.day = 6'd1;
    end else begin
      res.date.day = {1'b0, default_day};
    end
    res.flags = {!year_valid, !month_valid, !day_valid};
  end

endmodule

@@ sv/cda_step.sv @@
// Shared date step unit: one day, one month, a year add or the leap-day fix.
module cda_step (
  input  cda_pkg::date_t     cur,
  input  cda_pkg::step_op_t  op,
  input  logic [15:0]        amount,
  output cda_pkg::step_res_t res
);
  import cda_pkg::*;

  logic [5:0]  day_inc;
  logic [16:0] year_sum;
  date_t       month_rolled;
  logic        month_sat;

  always_comb begin
    day_inc  = cur.day + 6'd1;
    year_sum = {5'd0, cur.year} + {1'b0, amount};

    // One month forward; December rolls into January of the next year, unless the year is at its limit.
    month_rolled = cur;
    month_sat    = 1'b0;
    if (cur.month == MONTH_DEC) begin
      month_rolled.month = MONTH_JAN;
      if (cur.year == YEAR_LIMIT) begin
        month_sat = 1'b1;
      end else begin
        month_rolled.year = cur.year + 12'd1;
      end
    end else begin
      month_rolled.month = cur.month + 4'd1;
    end

    res.date = cur;
    res.sat  = 1'b0;
    unique case (op)
      OP_DAY: begin
        if (day_ok(day_inc, cur.month, cur.year)) begin
          res.date.day = day_inc;
        end else begin
          res.date     = month_rolled;
          res.date.day = 6'd1;
          res.sat      = month_sat;
        end
      end
      OP_MONTH: begin
        res.date = month_rolled;
        res.sat  = month_sat;
      end
      OP_YEARS: begin
        if (year_sum > {5'd0, YEAR_LIMIT}) begin
          res.date.year = YEAR_LIMIT;
          res.sat       = 1'b1;
        end else begin
          res.date.year = year_sum[11:0];
        end
      end
      OP_FEB: begin
        // 29 February that landed on a common year becomes 1 March.
        if ((cur.day == LEAP_DAY) && (cur.month == MONTH_FEB) && !is_leap(cur.year)) begin
          res.date.day   = 6'd1;
          res.date.month = MONTH_MAR;
        end
      end
      default: res.date = cur;
    endcase
  end

endmodule

@@ sv/calendar_date_adder_top.sv @@
// Gregorian date counter: holds a date and sets it or adds days, months or years.
// Each accepted word either sets the date (each field checked, invalid ones taken
// from the default registers and flagged) or adds an amount of days, months or
// years; years stop at 4095 and the step that hits the limit is flagged. The shared
// step unit moves the date by one day or one month per cycle; a year add is one step
// followed by the leap-day fix. The block takes no new word until the current one
// is finished, but it does accept one while the previous result word still waits
// in the output register. Default registers are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce it.
module calendar_date_adder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  cda_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output cda_pkg::out_item_t rsp,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import cda_pkg::*;

  state_t      state;
  state_t      state_next;
  in_item_t    item;
  in_item_t    item_next;
  date_t       cur;
  date_t       cur_next;
  logic [15:0] cnt;
  logic [15:0] cnt_next;
  logic        sat;
  logic        sat_next;
  logic [2:0]  flags;
  logic [2:0]  flags_next;
  logic        out_load;
  step_op_t    step_op;
  step_res_t   step_res;
  set_res_t    set_res;
  logic [4:0]  default_day;
  logic [3:0]  default_month;
  logic [11:0] default_year;

  // Default registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      default_day   <= RESET_DAY;
      default_month <= RESET_MONTH;
      default_year  <= RESET_YEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEFAULT_DAY:   default_day   <= cfg_data[4:0];
        REG_DEFAULT_MONTH: default_month <= cfg_data[3:0];
        REG_DEFAULT_YEAR:  default_year  <= cfg_data;
        default: ;
      endcase
    end
  end

  cda_set_check u_set_check (
    .item          (item),
    .default_day   (default_day),
    .default_month (default_month),
    .default_year  (default_year),
    .res           (set_res)
  );

  cda_step u_step (
    .cur    (cur),
    .op     (step_op),
    .amount (item.amount),
    .res    (step_res)
  );

  // Sequencer state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur.day   <= {1'b0, RESET_DAY};
      cur.month <= RESET_MONTH;
      cur.year  <= RESET_YEAR;
    end else begin
      state <= state_next;
      cur   <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    item  <= item_next;
    cnt   <= cnt_next;
    sat   <= sat_next;
    flags <= flags_next;
  end

  // Next state and step control.
  always_comb begin
    state_next = state;
    item_next  = item;
    cur_next   = cur;
    cnt_next   = cnt;
    sat_next   = sat;
    flags_next = flags;
    step_op    = OP_DAY;
    out_load   = 1'b0;
    req_ready  = (state == S_IDLE);

    unique case (state) inside
      S_IDLE: begin
        if (req_valid) begin
          item_next  = req;
          cnt_next   = req.amount;
          sat_next   = 1'b0;
          flags_next = 3'd0;
          unique case (req.action)
            ACT_SET:        state_next = S_SET;
            ACT_ADD_DAYS:   state_next = S_DAYS;
            ACT_ADD_MONTHS: state_next = S_MONTHS;
            ACT_ADD_YEARS:  state_next = S_YEARS;
            default:        state_next = S_SET;
          endcase
        end
      end
      S_SET: begin
        cur_next   = set_res.date;
        flags_next = set_res.flags;
        state_next = S_DONE;
      end
      S_DAYS, S_MONTHS: begin
        step_op = (state == S_DAYS) ? OP_DAY : OP_MONTH;
        if (cnt == 16'd0) begin
          state_next = S_DONE;
        end else begin
          cur_next = step_res.date;
          sat_next = sat | step_res.sat;
          cnt_next = cnt - 16'd1;
        end
      end
      S_YEARS: begin
        step_op    = OP_YEARS;
        cur_next   = step_res.date;
        sat_next   = step_res.sat;
        state_next = S_FEB;
      end
      S_FEB: begin
        step_op    = OP_FEB;
        cur_next   = step_res.date;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.day_out        <= cur.day[4:0];
      rsp.month_out      <= cur.month;
      rsp.year_out       <= cur.year;
      rsp.fallback_flags <= flags;
      rsp.year_saturated <= sat;
    end
  end

endmodule

@@ sv/cda_checker.sv @@
// Port-level checks for the date adder, bound to the top level.
module cda_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input cda_pkg::out_item_t rsp
);
  import cda_pkg::*;

  // A result word that is not taken stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // The block is busy in the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("new word taken while one is in work");

  // Every result carries a real month.
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.month_out >= MONTH_JAN) && (rsp.month_out <= MONTH_DEC))
    else $error("result month out of range");

  // Fallback flags come from sets only, saturation from adds only.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.fallback_flags != 3'd0) |-> !rsp.year_saturated)
    else $error("fallback and saturation flagged together");

endmodule

bind calendar_date_adder_top cda_checker u_cda_checker (.*);
